/* rtl/plc_pkg.sv */
`default_nettype none

package plc_pkg;

  localparam logic [1:0] PTR_UNUSED   = 2'd0;
  localparam logic [1:0] PTR_NORMAL   = 2'd1;
  localparam logic [1:0] PTR_REDIRECT = 2'd2;
  localparam logic [1:0] PTR_DEAD     = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPECIAL_LIMIT = 2'd1;

  localparam logic [14:0] UPPER_LIMIT_RESET   = 15'd0;
  localparam logic [14:0] SPECIAL_LIMIT_RESET = 15'd8192;

  localparam logic [8:0]  OVERLAP_MAX    = 9'd511;
  localparam logic [19:0] PAGE_TOTAL_MAX = 20'hFFFFF;

  typedef struct packed {
    logic        first_of_page;
    logic [1:0]  flags;
    logic [14:0] offset;
    logic [14:0] length;
  } plc_in_t;

  typedef struct packed {
    logic [9:0]  pointer_number;
    logic [2:0]  field_errors;
    logic [8:0]  overlap_count;
    logic [9:0]  pointer_errors;
    logic [19:0] page_errors;
  } plc_out_t;

  typedef struct packed {
    logic        valid;
    logic        first;
    logic        norm;
    logic [14:0] start;
    logic [15:0] stop;
    logic [8:0]  overlaps;
    logic [9:0]  pointer_number;
    logic [2:0]  field_errors;
  } plc_query_t;

endpackage

`default_nettype wire

/* rtl/plc_head.sv */
`default_nettype none

module plc_head
  import plc_pkg::*;
#(
  parameter int MAX_POINTERS = 512,
  parameter int CW           = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire plc_in_t                item,
  input  wire logic                   item_valid,
  input  wire logic                   advance,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [14:0]            cfg_data,
  output plc_query_t                  q,
  output logic [CW-1:0]               cnt
);

  localparam int PW = $clog2(MAX_POINTERS);
  localparam int NW = PW + 1;

  logic [PW-1:0] pointer_index;
  logic [CW-1:0] stored_count;
  logic [14:0]   upper_limit;
  logic [14:0]   special_limit;

  logic [PW-1:0] idx_cur;
  logic [CW-1:0] cnt_cur;
  logic [NW-1:0] number_full;
  logic [15:0]   stop;
  logic [2:0]    ferr;
  logic          norm;
  logic          accept;

  always_comb begin
    idx_cur     = item.first_of_page ? '0 : pointer_index;
    cnt_cur     = item.first_of_page ? '0 : stored_count;
    number_full = NW'(idx_cur) + NW'(1);
    stop        = 16'(item.offset) + 16'(item.length);
    norm        = (item.flags == PTR_NORMAL);
    ferr        = 3'd0;
    case (item.flags) inside
      PTR_UNUSED, PTR_REDIRECT: begin
        ferr = (item.length != 15'd0) ? 3'd1 : 3'd0;
      end
      PTR_NORMAL: begin
        ferr = 3'(item.length == 15'd0) + 3'(item.offset == 15'd0)
             + 3'(item.offset < upper_limit) + 3'(stop > 16'(special_limit));
      end
      default: ferr = 3'd0;
    endcase
  end

  always_comb begin
    q.valid          = item_valid;
    q.first          = item.first_of_page;
    q.norm           = norm;
    q.start          = item.offset;
    q.stop           = stop;
    q.overlaps       = 9'd0;
    q.pointer_number = 10'(number_full);
    q.field_errors   = ferr;
    cnt              = cnt_cur;
  end

  assign accept = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_index <= '0;
      stored_count  <= '0;
    end else if (accept) begin
      pointer_index <= (idx_cur < PW'(MAX_POINTERS - 1)) ? idx_cur + PW'(1) : idx_cur;
      stored_count  <= (norm && cnt_cur < CW'(MAX_POINTERS)) ? cnt_cur + CW'(1) : cnt_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit   <= UPPER_LIMIT_RESET;
      special_limit <= SPECIAL_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UPPER_LIMIT:   upper_limit   <= cfg_data;
        REG_SPECIAL_LIMIT: special_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/plc_cell.sv */
`default_nettype none

module plc_cell
  import plc_pkg::*;
#(
  parameter int CW   = 10,
  parameter int SLOT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire plc_query_t    q_in,
  input  wire logic [CW-1:0] cnt_in,
  output plc_query_t         q_out,
  output logic [CW-1:0]      cnt_out
);

  logic [14:0] start;
  logic [15:0] stop;
  logic        hit;
  logic        store;
  plc_query_t  q_out_next;

  assign hit   = q_in.norm && (cnt_in > CW'(SLOT))
              && (16'(q_in.start) < stop) && (16'(start) < q_in.stop);
  assign store = advance && q_in.valid && q_in.norm && (cnt_in == CW'(SLOT));

  always_comb begin
    q_out_next = q_in;
    if (hit && q_in.overlaps != OVERLAP_MAX) begin
      q_out_next.overlaps = q_in.overlaps + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      start <= q_in.start;
      stop  <= q_in.stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else if (advance) begin
      q_out   <= q_out_next;
      cnt_out <= cnt_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/plc_tail.sv */
`default_nettype none

module plc_tail
  import plc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire plc_query_t q_in,
  output logic            advance,
  output logic            result_valid,
  input  wire logic       result_ready,
  output plc_out_t        result
);

  logic [19:0] page_error_total;
  logic [19:0] base;
  logic [9:0]  ptr_err;
  logic [20:0] sum;
  logic [19:0] total_next;

  assign advance = !result_valid || result_ready;

  always_comb begin
    base       = q_in.first ? 20'd0 : page_error_total;
    ptr_err    = 10'(q_in.field_errors) + 10'(q_in.overlaps);
    sum        = 21'(base) + 21'(ptr_err);
    total_next = (sum > 21'(PAGE_TOTAL_MAX)) ? PAGE_TOTAL_MAX : sum[19:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_error_total <= '0;
      result_valid     <= 1'b0;
    end else if (advance) begin
      result_valid <= q_in.valid;
      if (q_in.valid) begin
        page_error_total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_in.valid) begin
      result.pointer_number <= q_in.pointer_number;
      result.field_errors   <= q_in.field_errors;
      result.overlap_count  <= q_in.overlaps;
      result.pointer_errors <= ptr_err;
      result.page_errors    <= total_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/page_line_pointer_checker.sv */
// The head grades an item combinationally; the MAX_POINTERS compare cells,
// then the tail's result register, hold it in turn. Throughput: one item per
// cycle while results are taken; the chain stalls while a result waits untaken.
// Reset (rst, synchronous): chain and result emptied, counters and page total
// cleared, upper_limit 0, special_limit 8192; stored intervals not cleared.
`default_nettype none

module page_line_pointer_checker
  import plc_pkg::*;
#(
  parameter int MAX_POINTERS = 512
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire plc_in_t                item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output plc_out_t                    result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [14:0]            cfg_data
);

  localparam int CW = $clog2(MAX_POINTERS + 1);

  plc_query_t    chain_q   [0:MAX_POINTERS];
  logic [CW-1:0] chain_cnt [0:MAX_POINTERS];
  logic          advance;

  assign item_ready = advance;
  assign cfg_ready  = 1'b1;

  plc_head #(
    .MAX_POINTERS (MAX_POINTERS),
    .CW           (CW)
  ) u_head (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .advance    (advance),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q          (chain_q[0]),
    .cnt        (chain_cnt[0])
  );

  for (genvar k = 0; k < MAX_POINTERS; k++) begin : g_cell
    plc_cell #(
      .CW   (CW),
      .SLOT (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .q_in    (chain_q[k]),
      .cnt_in  (chain_cnt[k]),
      .q_out   (chain_q[k+1]),
      .cnt_out (chain_cnt[k+1])
    );
  end

  plc_tail u_tail (
    .clk          (clk),
    .rst          (rst),
    .q_in         (chain_q[MAX_POINTERS]),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef ASSERT_OFF
  a_sum: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.pointer_errors ==
      10'(result.field_errors) + 10'(result.overlap_count))
    else $error("pointer_errors differs from field_errors plus overlap_count");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    chain_cnt[0] <= CW'(MAX_POINTERS))
    else $error("stored interval count beyond capacity");

  a_rst: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |-> !item_ready)
    else $error("item taken while chain stalled");
`endif

endmodule

`default_nettype wire

/* verif/tb_page_line_pointer_checker.sv */
`timescale 1ns / 100ps

module tb_page_line_pointer_checker;
  import plc_pkg::*;

  localparam int MAX_POINTERS = 512;
  localparam int HOLD_OFF_CYCLES = 3 * MAX_POINTERS;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE, RX_DENSE} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  plc_in_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  plc_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_UPPER_LIMIT;
  logic [14:0] cfg_data = '0;

  page_line_pointer_checker #(.MAX_POINTERS(MAX_POINTERS)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [14:0] upper_bound = UPPER_LIMIT_RESET;
  logic [14:0] special_bound = SPECIAL_LIMIT_RESET;
  logic [14:0] page_starts [MAX_POINTERS];
  logic [15:0] page_ends [MAX_POINTERS];
  int unsigned stored_total = 0;
  int unsigned next_index = 0;
  logic [19:0] page_total = '0;

  plc_out_t expected_reports[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit gaps_enabled = 1'b1;
  bit hold_off_req = 1'b0;

  function automatic plc_out_t grade_pointer(plc_in_t p);
    plc_out_t r;
    logic [15:0] stop;
    logic [2:0] ferr;
    logic [8:0] hits;
    logic [9:0] perr;
    logic [20:0] sum;
    int unsigned k;
    ferr = '0;
    hits = '0;
    if (p.first_of_page) begin
      stored_total = 0;
      next_index = 0;
      page_total = '0;
    end
    r.pointer_number = 10'(next_index + 1);
    case (p.flags)
      PTR_NORMAL: begin
        stop = {1'b0, p.offset} + {1'b0, p.length};
        if (p.length == '0) ferr++;
        if (p.offset == '0) ferr++;
        if (p.offset < upper_bound) ferr++;
        if (stop > {1'b0, special_bound}) ferr++;
        for (k = 0; k < stored_total; k++) begin
          if ({1'b0, p.offset} < page_ends[k] && {1'b0, page_starts[k]} < stop &&
              hits != OVERLAP_MAX) hits++;
        end
        if (stored_total < MAX_POINTERS) begin
          page_starts[stored_total] = p.offset;
          page_ends[stored_total] = stop;
          stored_total++;
        end
      end
      PTR_UNUSED, PTR_REDIRECT: ferr = (p.length != '0) ? 3'd1 : 3'd0;
      PTR_DEAD: ferr = '0;
    endcase
    perr = 10'(ferr) + 10'(hits);
    sum = 21'(page_total) + 21'(perr);
    page_total = (sum > 21'(PAGE_TOTAL_MAX)) ? PAGE_TOTAL_MAX : sum[19:0];
    if (next_index < MAX_POINTERS - 1) next_index++;
    r.field_errors = ferr;
    r.overlap_count = hits;
    r.pointer_errors = perr;
    r.page_errors = page_total;
    return r;
  endfunction

  function automatic plc_in_t make_pointer(logic first, logic [1:0] kind, int off, int len);
    plc_in_t p;
    p.first_of_page = first;
    p.flags = kind;
    p.offset = 15'(off);
    p.length = 15'(len);
    return p;
  endfunction

  function automatic plc_in_t random_pointer(logic first);
    plc_in_t p;
    p.first_of_page = first;
    p.flags = ($urandom_range(0, 9) < 6) ? PTR_NORMAL : 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: p.offset = '0;
      1: p.offset = '1;
      2, 3: p.offset = 15'($urandom);
      default: p.offset = 15'($urandom_range(1, 8191));
    endcase
    case ($urandom_range(0, 9))
      0: p.length = '0;
      1: p.length = '1;
      2: p.length = 15'($urandom);
      default: p.length = 15'($urandom_range(1, 400));
    endcase
    return p;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_pointer(plc_in_t p);
    item <= p;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    expected_reports.push_back(grade_pointer(p));
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        item_valid <= 1'b0;
        burst_left = $urandom_range(1, 24);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_page(int count);
    for (int i = 0; i < count; i++) send_pointer(random_pointer(i == 0));
  endtask

  task automatic wait_results_empty();
    if (item_valid) item_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [14:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_UPPER_LIMIT: upper_bound = value;
      REG_SPECIAL_LIMIT: special_bound = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(int upper, int special);
    wait_results_empty();
    write_register(REG_UPPER_LIMIT, 15'(upper));
    write_register(REG_SPECIAL_LIMIT, 15'(special));
  endtask

  task automatic test_directed_checks();
    send_pointer(make_pointer(1'b0, PTR_UNUSED, 0, 0));
    send_pointer(make_pointer(1'b0, PTR_UNUSED, 5, 1));
    send_pointer(make_pointer(1'b0, PTR_REDIRECT, 7, 0));
    send_pointer(make_pointer(1'b0, PTR_REDIRECT, 32767, 32767));
    send_pointer(make_pointer(1'b0, PTR_DEAD, 32767, 32767));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 0, 0));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 100, 50));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 100, 50));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 150, 10));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 120, 5));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 8000, 192));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 8000, 193));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 32767, 32767));
    set_limits(4096, 4200);
    send_pointer(make_pointer(1'b1, PTR_NORMAL, 4095, 10));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 4096, 104));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 4096, 105));
    send_pointer(make_pointer(1'b1, PTR_DEAD, 0, 0));
    send_pointer(make_pointer(1'b0, PTR_NORMAL, 4100, 1));
  endtask

  task automatic test_limit_settings();
    int uppers [7];
    int specials [7];
    uppers = '{0, 32767, 32767, 0, 0, 0, 0};
    specials = '{0, 32767, 0, 32767, 0, 0, 0};
    for (int s = 4; s < 7; s++) begin
      uppers[s] = $urandom_range(0, 8191);
      specials[s] = $urandom_range(0, 32767);
    end
    for (int s = 0; s < 7; s++) begin
      set_limits(uppers[s], specials[s]);
      repeat (2) send_page($urandom_range(1, 10));
    end
  endtask

  task automatic test_random_pages();
    int sent;
    int size;
    sent = 0;
    set_limits($urandom_range(0, 2048), $urandom_range(4096, 16384));
    while (sent < 200) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 30);
      gaps_enabled = ($urandom_range(0, 3) != 0);
      send_page(size);
      sent += size;
      if ($urandom_range(0, 5) == 0) wait_results_empty();
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_full_page();
    plc_in_t p;
    set_limits(32767, $urandom_range(0, 32767));
    gaps_enabled = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < MAX_POINTERS; i++)
      send_pointer(make_pointer(i == 0, PTR_NORMAL, $urandom_range(16, 32767),
                                $urandom_range(1, 32767)));
    for (int i = 0; i < 48; i++) begin
      if ($urandom_range(0, 9) == 0) p = random_pointer(1'b0);
      else p = make_pointer(1'b0, PTR_NORMAL, $urandom_range(1, 16), 32767);
      send_pointer(p);
    end
    gaps_enabled = 1'b1;
    set_limits(UPPER_LIMIT_RESET, SPECIAL_LIMIT_RESET);
    send_page(12);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_checks();
    test_limit_settings();
    test_random_pages();
    test_full_page();
    wait_results_empty();
    repeat (MAX_POINTERS + 16) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : receiver
    rx_mode_e mode;
    int seg_left;
    int held;
    mode = RX_STREAM;
    seg_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(5, 80);
        end
        seg_left--;
        case (mode)
          RX_STREAM: result_ready <= 1'b1;
          RX_HALF: result_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: result_ready <= ($urandom_range(0, 7) == 0);
          default: result_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    plc_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none actual %h", $time, result);
      end else begin
        want = expected_reports.pop_front();
        compare_field("pointer_number", want.pointer_number, result.pointer_number);
        compare_field("field_errors", want.field_errors, result.field_errors);
        compare_field("overlap_count", want.overlap_count, result.overlap_count);
        compare_field("pointer_errors", want.pointer_errors, result.pointer_errors);
        compare_field("page_errors", want.page_errors, result.page_errors);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
